[src/dwe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dwe_pkg;

  localparam int EnergyBits  = 41;
  localparam int CfgDataBits = 11;
  localparam int CfgIdxBits  = 2;
  localparam int DecimBits   = 8;

  localparam int WinLenReset = 1024;
  localparam logic [DecimBits-1:0] DecimStepReset   = 8'd1;
  localparam logic [DecimBits-1:0] DecimOffsetReset = 8'd0;

  typedef enum logic [CfgIdxBits-1:0] {
    RegWindowLength = 2'd0,
    RegDecimStep    = 2'd1,
    RegDecimOffset  = 2'd2
  } cfg_reg_e;

  // per-item decision from the decimator
  typedef struct packed {
    logic accept;     // sample enters the window
    logic old_valid;  // slot being replaced was written since the last clear
  } dec_ctl_t;

endpackage

`default_nettype wire

[src/decimating_window_energy.sv]
`timescale 1ns / 1ps
`default_nettype none

// Running sum of squares over the last window_length kept samples of a decimated
// audio stream. One item is taken every clock cycle unless the output stalls;
// its result reaches the outputs through the input stage with the window
// memory read, the squaring stage and the accumulate stage. The whole pipeline
// stalls only while a finished result is not taken, and no new item enters
// then. The window memory is single-ported with the
// old entry read in the same cycle as the new one is written. No clearing pass
// is needed after reset or after a window length write: slots fill in order from
// zero and a wrap flag marks when the slot being replaced holds real data, so
// the block is ready from the first cycle after reset. Every window length write
// empties the window and zeroes the energy; step and offset writes take effect
// at the next kept sample and the next block start respectively.
module decimating_window_energy #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [dwe_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  wire logic [dwe_pkg::CfgDataBits-1:0]    cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0]      sample_i,
  input  wire logic                               block_start_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic                                    accepted_o,
  output logic [dwe_pkg::EnergyBits-1:0]          energy_o
);

  localparam int LenBits = $clog2(MAX_WINDOW + 1);
  localparam int PtrBits = $clog2(MAX_WINDOW);
  localparam logic [LenBits-1:0] LenReset =
    LenBits'((dwe_pkg::WinLenReset > MAX_WINDOW) ? MAX_WINDOW : dwe_pkg::WinLenReset);

  logic [LenBits-1:0]            eff_len_q;
  logic [dwe_pkg::DecimBits-1:0] step_q, offset_q;
  logic                          clear;
  logic                          adv, in_fire;
  dwe_pkg::dec_ctl_t             ctl, s1_ctl_q;
  logic [PtrBits-1:0]            wr_ptr;
  logic                          s1_valid_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic [SAMPLE_BITS-1:0]        old_raw;
  logic [LenBits-1:0]            len_clamped;

  assign clear = cfg_we_i && (cfg_idx_i == dwe_pkg::RegWindowLength);

  // zero acts as one, anything past the memory depth as the full depth
  always_comb begin
    if (cfg_data_i == '0) begin
      len_clamped = LenBits'(1);
    end else if (32'(cfg_data_i) > MAX_WINDOW) begin
      len_clamped = LenBits'(MAX_WINDOW);
    end else begin
      len_clamped = LenBits'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_len_q <= LenReset;
      step_q    <= dwe_pkg::DecimStepReset;
      offset_q  <= dwe_pkg::DecimOffsetReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dwe_pkg::RegWindowLength: eff_len_q <= len_clamped;
        dwe_pkg::RegDecimStep:    step_q    <= cfg_data_i[dwe_pkg::DecimBits-1:0];
        dwe_pkg::RegDecimOffset:  offset_q  <= cfg_data_i[dwe_pkg::DecimBits-1:0];
        default: ;
      endcase
    end
  end

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;
  assign in_fire    = in_valid_i && adv;

  dwe_decim #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_decim (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .block_start_i (block_start_i),
    .clear_i       (clear),
    .eff_len_i     (eff_len_q),
    .step_i        (step_q),
    .offset_i      (offset_q),
    .ctl_o         (ctl),
    .wr_ptr_o      (wr_ptr)
  );

  dwe_window_mem #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .rd_en_i (in_fire),
    .wr_en_i (ctl.accept),
    .addr_i  (wr_ptr),
    .wdata_i (sample_i),
    .rdata_o (old_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_ctl_q   <= '0;
    end else if (adv) begin
      s1_valid_q <= in_fire;
      s1_ctl_q   <= ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_sample_q <= sample_i;
    end
  end

  dwe_energy #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_energy (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .clear_i      (clear),
    .valid_i      (s1_valid_q),
    .ctl_i        (s1_ctl_q),
    .new_sample_i (s1_sample_q),
    .old_sample_i ($signed(old_raw)),
    .valid_o      (out_valid_o),
    .accepted_o   (accepted_o),
    .energy_o     (energy_o)
  );

  a_ptr_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LenBits'(wr_ptr) < eff_len_q)
    else $error("write pointer outside the window");

  a_clear_zeroes_energy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> (energy_o == '0))
    else $error("energy not cleared by window length write");

  a_wrap_on_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.accept && !clear && (LenBits'(wr_ptr) + LenBits'(1) == eff_len_q))
      |=> (wr_ptr == '0) && u_decim.ctl_o.old_valid)
    else $error("pointer did not wrap after last slot");

endmodule

`default_nettype wire

[src/dwe_decim.sv]
`timescale 1ns / 1ps
`default_nettype none

module dwe_decim #(
  parameter int MAX_WINDOW = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             fire_i,
  input  wire logic                             block_start_i,
  input  wire logic                             clear_i,
  input  wire logic [$clog2(MAX_WINDOW+1)-1:0]  eff_len_i,
  input  wire logic [dwe_pkg::DecimBits-1:0]    step_i,
  input  wire logic [dwe_pkg::DecimBits-1:0]    offset_i,
  output dwe_pkg::dec_ctl_t                     ctl_o,
  output logic [$clog2(MAX_WINDOW)-1:0]         wr_ptr_o
);

  localparam int LenBits = $clog2(MAX_WINDOW + 1);
  localparam int PtrBits = $clog2(MAX_WINDOW);

  logic [dwe_pkg::DecimBits-1:0] skip_q, skip_d, skip_eff;
  logic [LenBits-1:0]            blk_q, blk_d, blk_eff;
  logic [PtrBits-1:0]            ptr_q, ptr_d;
  logic                          wrapped_q, wrapped_d;
  logic                          acc;
  logic [LenBits-1:0]            ptr_inc;

  always_comb begin
    skip_eff = block_start_i ? offset_i : skip_q;
    blk_eff  = block_start_i ? '0 : blk_q;
    acc      = 1'b0;
    skip_d   = skip_q;
    blk_d    = blk_q;
    if (fire_i) begin
      skip_d = skip_eff;
      blk_d  = blk_eff;
      if (blk_eff < eff_len_i) begin
        if (skip_eff == '0) begin
          acc    = 1'b1;
          blk_d  = blk_eff + LenBits'(1);
          skip_d = (step_i == '0) ? '0 : step_i - dwe_pkg::DecimBits'(1);
        end else begin
          skip_d = skip_eff - dwe_pkg::DecimBits'(1);
        end
      end
    end
  end

  // slots fill in order from zero, so a slot holds data once the pointer has wrapped
  assign ptr_inc = LenBits'(ptr_q) + LenBits'(1);

  always_comb begin
    ptr_d     = ptr_q;
    wrapped_d = wrapped_q;
    if (clear_i) begin
      ptr_d     = '0;
      wrapped_d = 1'b0;
    end else if (acc) begin
      if (ptr_inc >= eff_len_i) begin
        ptr_d     = '0;
        wrapped_d = 1'b1;
      end else begin
        ptr_d = ptr_inc[PtrBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q    <= '0;
      blk_q     <= '0;
      ptr_q     <= '0;
      wrapped_q <= 1'b0;
    end else begin
      skip_q    <= skip_d;
      blk_q     <= blk_d;
      ptr_q     <= ptr_d;
      wrapped_q <= wrapped_d;
    end
  end

  assign ctl_o.accept    = acc;
  assign ctl_o.old_valid = wrapped_q;
  assign wr_ptr_o        = ptr_q;

endmodule

`default_nettype wire

[src/dwe_window_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module dwe_window_mem #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rd_en_i,
  input  wire logic                          wr_en_i,
  input  wire logic [$clog2(MAX_WINDOW)-1:0] addr_i,
  input  wire logic [SAMPLE_BITS-1:0]        wdata_i,
  output logic [SAMPLE_BITS-1:0]             rdata_o
);

  logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rdata_q;

  // read returns the entry as it was before a write to the same slot
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/dwe_energy.sv]
`timescale 1ns / 1ps
`default_nettype none

module dwe_energy #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              adv_i,
  input  wire logic                              clear_i,
  input  wire logic                              valid_i,
  input  wire dwe_pkg::dec_ctl_t                 ctl_i,
  input  wire logic signed [SAMPLE_BITS-1:0]     new_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0]     old_sample_i,
  output logic                                   valid_o,
  output logic                                   accepted_o,
  output logic [dwe_pkg::EnergyBits-1:0]         energy_o
);

  localparam int EBits = dwe_pkg::EnergyBits;

  logic signed [2*SAMPLE_BITS-1:0] prod_new, prod_old;
  logic [EBits-1:0]                sq_new_q, sq_old_q;
  logic                            s2_valid_q, s2_acc_q;
  logic                            out_valid_q, accepted_q;
  logic [EBits-1:0]                energy_q, energy_d;

  assign prod_new = new_sample_i * new_sample_i;
  assign prod_old = old_sample_i * old_sample_i;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sq_new_q <= EBits'($unsigned(prod_new));
      sq_old_q <= ctl_i.old_valid ? EBits'($unsigned(prod_old)) : '0;
    end
  end

  always_comb begin
    energy_d = energy_q;
    if (clear_i) begin
      energy_d = '0;
    end else if (adv_i && s2_valid_q && s2_acc_q) begin
      energy_d = energy_q + sq_new_q - sq_old_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s2_acc_q    <= 1'b0;
      out_valid_q <= 1'b0;
      accepted_q  <= 1'b0;
      energy_q    <= '0;
    end else begin
      energy_q <= energy_d;
      if (adv_i) begin
        s2_valid_q  <= valid_i;
        s2_acc_q    <= valid_i & ctl_i.accept;
        out_valid_q <= s2_valid_q;
        if (s2_valid_q) begin
          accepted_q <= s2_acc_q;
        end
      end
    end
  end

  assign valid_o    = out_valid_q;
  assign accepted_o = accepted_q;
  assign energy_o   = energy_q;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import dwe_pkg::*;

  localparam int MaxWindow  = 1024;
  localparam int SampleBits = 16;
  localparam int LongHold   = 200;
  localparam int DrainWait  = 8;
  localparam logic [CfgIdxBits-1:0] RegSpare = 2'd3;

  typedef struct {
    logic signed [SampleBits-1:0] smp;
    logic                         bs;
  } sample_item_t;

  typedef struct {
    logic                  acc;
    logic [EnergyBits-1:0] energy;
  } energy_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SampleBits-1:0] sample_d = '0;
  logic bs_d = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic accepted;
  logic [EnergyBits-1:0] energy;

  decimating_window_energy #(
    .MAX_WINDOW (MaxWindow),
    .SAMPLE_BITS(SampleBits)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .sample_i     (sample_d),
    .block_start_i(bs_d),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .accepted_o   (accepted),
    .energy_o     (energy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted block state
  logic [SampleBits-1:0] win [MaxWindow];
  int                    win_ptr = 0;
  logic [EnergyBits-1:0] esum = '0;
  logic [7:0]            skip_left = '0;
  int                    blk_acc = 0;
  logic [CfgDataBits-1:0] p_len = CfgDataBits'(WinLenReset);
  logic [7:0]            p_step = DecimStepReset;
  logic [7:0]            p_offset = DecimOffsetReset;

  sample_item_t sample_q [$];
  energy_rec_t  energy_due [$];

  int send_idle_pct = 31;
  int recv_idle_pct = 65;
  int stall_reqs = 0;
  int stall_done = 0;
  int hold_left = 0;
  logic in_took = 1'b0;

  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_acc = 0;
  int n_settings = 0;

  function automatic logic [EnergyBits-1:0] square16(logic [SampleBits-1:0] v);
    longint s;
    s = $signed(v);
    return EnergyBits'(s * s);
  endfunction

  function automatic int eff_len();
    if (p_len == 0) return 1;
    if (p_len > MaxWindow) return MaxWindow;
    return p_len;
  endfunction

  task automatic clear_window();
    for (int k = 0; k < MaxWindow; k++) win[k] = '0;
    win_ptr = 0;
    esum = '0;
  endtask

  task automatic advance_window(input logic [SampleBits-1:0] smp, input logic bs,
                                output energy_rec_t rec);
    int len;
    int wp;
    len = eff_len();
    rec.acc = 1'b0;
    if (bs) begin
      skip_left = p_offset;
      blk_acc = 0;
    end
    if (blk_acc < len) begin
      if (skip_left == 0) begin
        wp = (win_ptr >= len) ? 0 : win_ptr;
        esum = esum - square16(win[wp]) + square16(smp);
        win[wp] = smp;
        wp++;
        win_ptr = (wp >= len) ? 0 : wp;
        blk_acc++;
        skip_left = (p_step == 0) ? 8'd0 : p_step - 8'd1;
        rec.acc = 1'b1;
      end else begin
        skip_left--;
      end
    end
    rec.energy = esum;
  endtask

  // driver: one item offered at a time, held until its transfer
  always @(negedge clk) begin : drive
    logic nv;
    logic signed [SampleBits-1:0] ns;
    logic nb;
    sample_item_t it;
    nv = in_valid;
    ns = sample_d;
    nb = bs_d;
    if (in_valid && in_took) nv = 1'b0;
    if (!nv && rst_n && sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      it = sample_q.pop_front();
      ns = it.smp;
      nb = it.bs;
      nv = 1'b1;
    end
    in_valid <= nv;
    sample_d <= ns;
    bs_d <= nb;
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin : recv
    logic r;
    if (stall_reqs != stall_done) begin
      stall_done = stall_reqs;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      r = 1'b0;
    end else begin
      r = ($urandom_range(99) >= recv_idle_pct);
    end
    out_ready <= r;
  end

  always @(posedge clk) begin : watch
    energy_rec_t rec;
    energy_rec_t want;
    in_took <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        advance_window(sample_d, bs_d, rec);
        energy_due.push_back(rec);
        n_in++;
      end
      if (out_valid && out_ready) begin
        n_out++;
        if (energy_due.size() == 0) begin
          errors++;
          $display("%0t: result with nothing pending: accepted=%0b energy=%0d",
                   $time, accepted, energy);
        end else begin
          want = energy_due.pop_front();
          if (want.acc) n_acc++;
          if (accepted !== want.acc) begin
            errors++;
            $display("%0t: accepted mismatch: expected %0b actual %0b",
                     $time, want.acc, accepted);
          end
          if (energy !== want.energy) begin
            errors++;
            $display("%0t: energy mismatch: expected %0d actual %0d",
                     $time, want.energy, energy);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      RegWindowLength: begin
        p_len = data;
        clear_window();
      end
      RegDecimStep:   p_step = data[7:0];
      RegDecimOffset: p_offset = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic settle();
    while (sample_q.size() > 0 || in_valid || energy_due.size() > 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic push_item(input logic [SampleBits-1:0] smp, input logic bs);
    sample_item_t it;
    it.smp = smp;
    it.bs = bs;
    sample_q.push_back(it);
  endtask

  // well-formed blocks with random content, a few with stray block starts
  task automatic queue_blocks(input int count, input logic carry);
    int len;
    int span;
    int blen;
    logic noisy;
    logic first;
    logic [SampleBits-1:0] smp;
    len = eff_len();
    span = p_offset + len * ((p_step == 0) ? 1 : p_step) + 2;
    if (span > 120) span = 120;
    first = 1'b1;
    while (count > 0) begin
      blen = $urandom_range(span, 1);
      noisy = ($urandom_range(9) == 0);
      for (int i = 0; i < blen && count > 0; i++) begin
        smp = SampleBits'($urandom);
        if ($urandom_range(15) == 0) begin
          case ($urandom_range(3))
            0: smp = 16'h7FFF;
            1: smp = 16'h8000;
            2: smp = 16'h0000;
            default: smp = 16'hFFFF;
          endcase
        end
        if (noisy) push_item(smp, $urandom_range(3) == 0);
        else push_item(smp, (i == 0) && !(first && carry));
        count--;
      end
      first = 1'b0;
    end
  endtask

  initial begin : timeout
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin : main
    logic [CfgDataBits-1:0] d;
    clear_window();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: samples before any block start, at reset settings
    push_item(16'h7FFF, 1'b0);
    push_item(16'h8000, 1'b0);
    push_item(16'h0000, 1'b0);
    push_item(16'hFFFF, 1'b0);
    push_item(16'h0001, 1'b1);
    settle();

    // short window: block limit and wrap
    write_reg(RegWindowLength, 11'd2);
    write_reg(RegDecimStep, 11'd1);
    write_reg(RegDecimOffset, 11'd0);
    @(posedge clk);
    push_item(16'h8000, 1'b1);
    push_item(16'h7FFF, 1'b0);
    push_item(16'd5, 1'b0);
    push_item(16'd100, 1'b1);
    push_item(16'd200, 1'b0);
    settle();

    // zero length, zero step, offset, block too short, ignored index
    write_reg(RegWindowLength, 11'd0);
    write_reg(RegDecimStep, 11'h100);
    write_reg(RegDecimOffset, 11'd2);
    write_reg(RegSpare, 11'h7FF);
    @(posedge clk);
    push_item(16'd7, 1'b1);
    push_item(16'd9, 1'b0);
    push_item(16'd11, 1'b1);
    push_item(16'd12, 1'b1);
    push_item(16'd13, 1'b0);
    push_item(16'd14, 1'b0);
    push_item(16'd15, 1'b0);
    settle();

    // oversize length, largest step and offset
    write_reg(RegWindowLength, 11'h7FF);
    write_reg(RegDecimStep, 11'd255);
    write_reg(RegDecimOffset, 11'd255);
    @(posedge clk);
    push_item(16'h7FFF, 1'b1);
    push_item(16'h8000, 1'b0);
    settle();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0 || $urandom_range(1) == 1) begin
        case ($urandom_range(9))
          0: d = 11'd0;
          1: d = 11'd1;
          2: d = 11'h7FF;
          3: d = 11'd1024;
          4: d = CfgDataBits'($urandom_range(2047, 1025));
          default: d = CfgDataBits'($urandom_range(12, 2));
        endcase
        write_reg(RegWindowLength, d);
      end
      d[10:8] = 3'($urandom);
      case ($urandom_range(7))
        0: d[7:0] = 8'd0;
        1: d[7:0] = 8'd255;
        default: d[7:0] = 8'($urandom_range(4, 1));
      endcase
      write_reg(RegDecimStep, d);
      d[10:8] = 3'($urandom);
      case ($urandom_range(7))
        0: d[7:0] = 8'd255;
        1: d[7:0] = 8'd0;
        default: d[7:0] = 8'($urandom_range(4, 0));
      endcase
      write_reg(RegDecimOffset, d);
      if ($urandom_range(3) == 0) write_reg(RegSpare, 11'($urandom));
      @(posedge clk);
      if (ph < 4) begin
        send_idle_pct = 31;
        recv_idle_pct = 65;
      end else if (ph < 8) begin
        send_idle_pct = 65;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // output held off while input keeps coming, to back up the pipeline
      if (ph == 8) stall_reqs++;
      queue_blocks(104, $urandom_range(2) == 0);
      settle();
    end

    repeat (20) @(posedge clk);
    $display("tb_top: %0d samples in, %0d results checked, %0d kept in the window",
             n_in, n_out, n_acc);
    $display("tb_top: %0d register writes, window lengths from 0 to 2047", n_settings);
    if (errors == 0 && energy_due.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      if (energy_due.size() != 0)
        $display("%0t: %0d results never arrived", $time, energy_due.size());
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
